/* rtl/core/fmpd_pkg.sv */
package fmpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEAD_BYTE        = 2'd0;
  localparam logic [1:0] CFG_TAIL_BYTE        = 2'd1;
  localparam logic [1:0] CFG_DIRECTION_ENABLE = 2'd2;

  // Mode counter slots: slot = mode code + 1.
  localparam int unsigned MODE_SLOTS     = 5;
  localparam logic [2:0]  SLOT_CROSSING  = 3'd0;
  localparam logic [2:0]  SLOT_ZEBRA     = 3'd2;
  localparam logic [2:0]  FAST_LIMIT     = 3'd2;
  localparam logic [2:0]  SLOW_LIMIT     = 3'd4;
  localparam logic [2:0]  DIR_LIMIT      = 3'd4;

  // Signed codes used on the result channel.
  localparam logic [1:0] DIR_LEFT  = 2'b01;
  localparam logic [1:0] DIR_RIGHT = 2'b11;
  localparam logic [2:0] MODE_CROSSING = 3'b111;

  // One classified byte, handed from the deframer to the debounce stage.
  typedef struct packed {
    logic       done;
    logic [7:0] bias;
    logic       mode_hit;
    logic [2:0] mode_slot;
    logic       dir_hit;
    logic       dir_sel;
  } fmpd_rec_t;

endpackage

/* rtl/core/framed_mode_packet_debouncer_top.sv */
// Packet deframer and mode debouncer for a serial byte stream.
// Input channel: one received byte per transaction on in_rx_byte, handshake
// in_valid / in_stall. Every accepted byte yields exactly one result
// transaction on the out_ channel, handshake out_valid / out_stall.
// out_frame_done marks a byte that closed a good packet; line bias, mode and
// lane direction are the latched values after that byte, and speed request
// and crossing clear pulse on the result that confirms the crossing mode.
// An accepted byte's record is written into the two-entry queue, then
// passes through the debounce stage into the result register. Throughput
// is one byte per cycle while out_stall is low, set by the single-cycle
// deframer and the single-cycle counter update in the back end. When the
// receiver stalls, the result register holds, the queue fills and in_stall
// rises once both queue entries are taken. Configuration (head byte, tail
// byte, direction enable) is written through cfg_we / cfg_index / cfg_wdata
// by the user only while no transaction is in flight; the block does not
// enforce this. Synchronous reset clears the deframer, counters and latched
// values and sets head and tail bytes to 0 with direction tracking enabled.
module framed_mode_packet_debouncer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_done,
  output logic signed [7:0] out_line_bias,
  output logic signed [2:0] out_drive_mode,
  output logic signed [1:0] out_lane_direction,
  output logic              out_speed_request,
  output logic              out_cross_clear
);
  import fmpd_pkg::*;

  logic [7:0] head_r, tail_r;
  logic       dir_en_r;
  logic       push, full, pop, not_empty;
  fmpd_rec_t  front_rec, queue_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= 8'd0;
      tail_r   <= 8'd0;
      dir_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD_BYTE:        head_r   <= cfg_wdata;
        CFG_TAIL_BYTE:        tail_r   <= cfg_wdata;
        CFG_DIRECTION_ENABLE: dir_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  fmpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rx_byte   (in_rx_byte),
    .head_byte (head_r),
    .tail_byte (tail_r),
    .rec       (front_rec)
  );

  fmpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (front_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_rec   (queue_rec)
  );

  fmpd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (not_empty),
    .rec                (queue_rec),
    .pop                (pop),
    .dir_en             (dir_en_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_done     (out_frame_done),
    .out_line_bias      (out_line_bias),
    .out_drive_mode     (out_drive_mode),
    .out_lane_direction (out_lane_direction),
    .out_speed_request  (out_speed_request),
    .out_cross_clear    (out_cross_clear)
  );

endmodule

/* rtl/core/fmpd_front.sv */
module fmpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         head_byte,
  input  logic [7:0]         tail_byte,
  output fmpd_pkg::fmpd_rec_t rec
);
  import fmpd_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TAIL    = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] bias_r, bias_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] dir_r, dir_nxt;

  // Deframing state machine, advanced once per accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    bias_nxt  = bias_r;
    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    rec       = '0;
    rec.bias  = bias_r;
    if (push) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == head_byte) phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          unique case (idx_r)
            2'd0: begin
              bias_nxt = rx_byte;
              idx_nxt  = 2'd1;
            end
            2'd1: begin
              mode_nxt = rx_byte;
              idx_nxt  = 2'd2;
            end
            default: begin
              dir_nxt   = rx_byte;
              idx_nxt   = 2'd0;
              phase_nxt = PH_TAIL;
            end
          endcase
        end
        PH_TAIL: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == tail_byte) rec.done = 1'b1;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
    // Classify the held codes so the back end only counts.
    rec.mode_hit  = (mode_r == 8'hFF) || (mode_r <= 8'd3);
    rec.mode_slot = (mode_r == 8'hFF) ? SLOT_CROSSING : (mode_r[2:0] + 3'd1);
    rec.dir_hit   = (dir_r == 8'd1) || (dir_r == 8'd2);
    rec.dir_sel   = (dir_r == 8'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= 2'd0;
      bias_r  <= 8'd0;
      mode_r  <= 8'd0;
      dir_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      bias_r  <= bias_nxt;
      mode_r  <= mode_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

/* rtl/core/fmpd_queue.sv */
module fmpd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fmpd_pkg::fmpd_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output fmpd_pkg::fmpd_rec_t pop_rec
);
  import fmpd_pkg::*;

  fmpd_rec_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_rec   = slot_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

endmodule

/* rtl/core/fmpd_back.sv */
module fmpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_valid,
  input  fmpd_pkg::fmpd_rec_t rec,
  output logic                pop,
  input  logic                dir_en,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_frame_done,
  output logic signed [7:0]   out_line_bias,
  output logic signed [2:0]   out_drive_mode,
  output logic signed [1:0]   out_lane_direction,
  output logic                out_speed_request,
  output logic                out_cross_clear
);
  import fmpd_pkg::*;

  logic [7:0] bias_r, bias_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [2:0] mode_cnt_r [MODE_SLOTS];
  logic [2:0] mode_cnt_nxt [MODE_SLOTS];
  logic [2:0] dir_cnt_r [2];
  logic [2:0] dir_cnt_nxt [2];
  logic       pulse;
  logic [2:0] limit;
  logic       valid_r, valid_nxt;
  logic       done_r;
  logic [7:0] obias_r;
  logic [2:0] omode_r;
  logic [1:0] odir_r;
  logic       pulse_r;

  // Take the next transaction whenever the output register is free or draining.
  assign pop = rec_valid && (!valid_r || !out_stall);

  // Debounce counters and latched outputs.
  always_comb begin
    bias_nxt     = bias_r;
    mode_nxt     = mode_r;
    dir_nxt      = dir_r;
    mode_cnt_nxt = mode_cnt_r;
    dir_cnt_nxt  = dir_cnt_r;
    pulse        = 1'b0;
    limit = ((rec.mode_slot == SLOT_CROSSING) || (rec.mode_slot == SLOT_ZEBRA)) ?
            FAST_LIMIT : SLOW_LIMIT;
    if (pop && rec.done) begin
      bias_nxt = rec.bias;
      if (rec.mode_hit) begin
        if (mode_cnt_r[rec.mode_slot] >= limit) begin
          mode_cnt_nxt[rec.mode_slot] = 3'd0;
          mode_nxt = rec.mode_slot - 3'd1;
          pulse    = (rec.mode_slot == SLOT_CROSSING);
        end else begin
          mode_cnt_nxt[rec.mode_slot] = mode_cnt_r[rec.mode_slot] + 3'd1;
        end
      end
      if (dir_en && rec.dir_hit) begin
        if (dir_cnt_r[rec.dir_sel] >= DIR_LIMIT) begin
          dir_nxt = rec.dir_sel ? DIR_RIGHT : DIR_LEFT;
        end else begin
          dir_cnt_nxt[rec.dir_sel] = dir_cnt_r[rec.dir_sel] + 3'd1;
        end
      end
    end
    valid_nxt = pop ? 1'b1 : (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r     <= 8'd0;
      mode_r     <= 3'd0;
      dir_r      <= 2'd0;
      mode_cnt_r <= '{default: 3'd0};
      dir_cnt_r  <= '{default: 3'd0};
      valid_r    <= 1'b0;
    end else begin
      bias_r     <= bias_nxt;
      mode_r     <= mode_nxt;
      dir_r      <= dir_nxt;
      mode_cnt_r <= mode_cnt_nxt;
      dir_cnt_r  <= dir_cnt_nxt;
      valid_r    <= valid_nxt;
    end
  end

  // Result register, loaded with each popped transaction.
  always_ff @(posedge clk) begin
    if (pop) begin
      done_r  <= rec.done;
      obias_r <= bias_nxt;
      omode_r <= mode_nxt;
      odir_r  <= dir_en ? dir_nxt : DIR_LEFT;
      pulse_r <= pulse;
    end
  end

  assign out_valid          = valid_r;
  assign out_frame_done     = done_r;
  assign out_line_bias      = obias_r;
  assign out_drive_mode     = omode_r;
  assign out_lane_direction = odir_r;
  assign out_speed_request  = pulse_r;
  assign out_cross_clear    = pulse_r;

  // A speed request only comes with a frame that confirms the crossing mode.
  a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && pulse_r) |-> (done_r && omode_r == MODE_CROSSING))
    else $error("speed request without confirmed crossing mode");

  // Direction counters saturate and never run past the limit.
  a_dir_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_cnt_r[0] <= DIR_LIMIT) && (dir_cnt_r[1] <= DIR_LIMIT))
    else $error("direction counter past saturation");

  // Mode counters clear when they fire, so none passes its limit, fast or slow.
  a_mode_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_cnt_r[0] <= FAST_LIMIT) && (mode_cnt_r[2] <= FAST_LIMIT) &&
    (mode_cnt_r[1] <= SLOW_LIMIT) && (mode_cnt_r[3] <= SLOW_LIMIT) &&
    (mode_cnt_r[4] <= SLOW_LIMIT))
    else $error("mode counter past its limit");

  // A popped transaction always shows up as a valid result next cycle.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped transaction lost");

endmodule
